// ----- rtl/deadline_watchdog_table_defines.svh -----
// ============================================================================
// Deadline watchdog table assertion macros
// Shared concurrent assertion forms for the table's checker.
// ============================================================================
`ifndef DEADLINE_WATCHDOG_TABLE_DEFINES_SVH
`define DEADLINE_WATCHDOG_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DWT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwt_chk: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DWT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwt_chk: next-cycle check failed");

`endif

// ----- rtl/dwt_pkg.sv -----
// ============================================================================
// Deadline watchdog table package
// Field widths, operation and kind codes, and shared structure types.
// ============================================================================
package dwt_pkg;

   localparam int OP_W     = 3;
   localparam int ID_W     = 22;
   localparam int AGE_W    = 20;
   localparam int KIND_W   = 3;
   localparam int IDX_W    = 6;
   localparam int DIV_W    = 4;
   localparam int DIV_CNT_W = $clog2(AGE_W + 1);

   localparam logic [AGE_W-1:0] AGE_MAX       = '1;
   localparam logic [DIV_W-1:0] AGE_DIV_RESET = 4'd2;

   localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_AGE  = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OP_W-1:0] OP_SWEEP    = 3'd4;

   localparam logic [KIND_W-1:0] KIND_HB_SEND  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HB_RECV  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RECORD   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_VIEW     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LONG_JOB = 3'd5;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [AGE_W-1:0]  age;
      logic [AGE_W-1:0]  deadline;
      logic [KIND_W-1:0] kind;
   } slot_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
      logic [KIND_W-1:0] kind;
   } expired_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  slot_index;
      logic [IDX_W-1:0]  free_slots;
      logic              expired_valid;
      logic [ID_W-1:0]   expired_id;
      logic [KIND_W-1:0] expired_kind;
      logic              peer_error;
      logic              record_expired;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [AGE_W-1:0] dividend;
      logic [AGE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AGE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/dwt_req_if.sv -----
// ============================================================================
// Deadline watchdog table request channel
// Valid/ready channel that carries one table operation per transfer.
// ============================================================================
interface dwt_req_if;

   logic                         valid;
   logic                         ready;
   logic [dwt_pkg::OP_W-1:0]     operation;
   logic [dwt_pkg::ID_W-1:0]     entry_id;
   logic [dwt_pkg::AGE_W-1:0]    deadline_ticks;
   logic [dwt_pkg::KIND_W-1:0]   entry_kind;
   logic [dwt_pkg::AGE_W-1:0]    age_value;

   modport source (
      output valid, operation, entry_id, deadline_ticks, entry_kind, age_value,
      input  ready
   );

   modport sink (
      input  valid, operation, entry_id, deadline_ticks, entry_kind, age_value,
      output ready
   );

endinterface

// ----- rtl/dwt_rsp_if.sv -----
// ============================================================================
// Deadline watchdog table response channel
// Valid/ready channel that carries one result item per transfer.
// ============================================================================
interface dwt_rsp_if;

   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [dwt_pkg::IDX_W-1:0]    slot_index;
   logic [dwt_pkg::IDX_W-1:0]    free_slots;
   logic                         expired_valid;
   logic [dwt_pkg::ID_W-1:0]     expired_id;
   logic [dwt_pkg::KIND_W-1:0]   expired_kind;
   logic                         peer_error;
   logic                         record_expired;
   logic                         last;

   modport source (
      output valid, found, slot_index, free_slots, expired_valid, expired_id,
             expired_kind, peer_error, record_expired, last,
      input  ready
   );

   modport sink (
      input  valid, found, slot_index, free_slots, expired_valid, expired_id,
             expired_kind, peer_error, record_expired, last,
      output ready
   );

endinterface

// ----- rtl/dwt_div.sv -----
// ============================================================================
// Deadline watchdog table age divider
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module dwt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dwt_pkg::div_req_type div_req,
   output dwt_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [dwt_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [dwt_pkg::AGE_W-1:0]       rem_ff, rem_in;
   logic [dwt_pkg::AGE_W-1:0]       quo_ff, quo_in;
   logic [dwt_pkg::AGE_W-1:0]       dsr_ff, dsr_in;
   logic [dwt_pkg::AGE_W:0]         trial;
   logic [dwt_pkg::AGE_W:0]         diff;

   assign trial = {rem_ff, quo_ff[dwt_pkg::AGE_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = dwt_pkg::DIV_CNT_W'(dwt_pkg::AGE_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[dwt_pkg::AGE_W-1:0];
            quo_in = {quo_ff[dwt_pkg::AGE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[dwt_pkg::AGE_W-1:0];
            quo_in = {quo_ff[dwt_pkg::AGE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - dwt_pkg::DIV_CNT_W'(1);
         if (cnt_ff == dwt_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/deadline_watchdog_table.sv -----
// ============================================================================
// Deadline watchdog table
// Slot table of watched entries held in a synchronous memory, with lookup,
// tick aging and an expiry sweep that removes and reports expired entries but only flags heartbeat ones.
// ============================================================================
// Register, remove and set age read and check one slot after another up to
// a match; tick visits every slot. A sweep reads and compares each slot, sends
// the age of each slot that needs it through the shared divider, makes a
// second divide pass over all slots after any record or long-job removal, and
// then sends its results. One item is in work at a time; the single memory port sets the rate.
// Reset empties the table at once through per-slot valid bits; divisor is 2.
module deadline_watchdog_table #(
   parameter int SLOTS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   dwt_req_if.sink                   req_bus,
   dwt_rsp_if.source                 rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [dwt_pkg::DIV_W-1:0] csr_wr_data
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = dwt_pkg::AGE_W + dwt_pkg::DIV_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_EV    = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_ORES  = 3'd5;
   localparam logic [2:0] S_OLD   = 3'd6;
   localparam logic [2:0] S_OLAST = 3'd7;

   localparam logic [1:0] M_MATCH = 2'd0;
   localparam logic [1:0] M_TICK  = 2'd1;
   localparam logic [1:0] M_SWEEP = 2'd2;
   localparam logic [1:0] M_DIVP  = 2'd3;

   dwt_pkg::slot_type    slot_mem [SLOTS];
   dwt_pkg::expired_type res_mem  [SLOTS];

   logic [2:0]                     state_ff, state_in;
   logic [1:0]                     mode_ff, mode_in;
   logic [AW-1:0]                  slot_ff, slot_in;
   logic [SLOTS-1:0]               valid_ff, valid_in;
   logic [dwt_pkg::IDX_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [CW-1:0]                  res_cnt_ff, res_cnt_in;
   logic [CW-1:0]                  out_k_ff, out_k_in;
   logic                           found_ff, found_in;
   logic [dwt_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic                           peer_ff, peer_in;
   logic                           rec_ff, rec_in;
   logic [dwt_pkg::AGE_W-1:0]      dscale_ff, dscale_in;
   logic                           big_ff, big_in;
   logic                           kill_ff, kill_in;
   logic [dwt_pkg::DIV_W-1:0]      age_divisor_ff, age_divisor_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [dwt_pkg::OP_W-1:0]       op_ff, op_in;
   logic [dwt_pkg::ID_W-1:0]       key_ff, key_in;
   logic [dwt_pkg::ID_W-1:0]       id_ff, id_in;
   logic [dwt_pkg::AGE_W-1:0]      dl_ff, dl_in;
   logic [dwt_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [dwt_pkg::AGE_W-1:0]      av_ff, av_in;
   logic [dwt_pkg::AGE_W-1:0]      eff_age_ff, eff_age_in;
   dwt_pkg::rsp_type               rsp_ff, rsp_in;

   dwt_pkg::slot_type              rd_ff;
   logic                           rd_valid_ff;
   dwt_pkg::expired_type           res_rd_ff;

   dwt_pkg::slot_type              rd_eff;
   dwt_pkg::slot_type              mem_wdata;
   logic                           mem_we;
   logic                           res_we;
   dwt_pkg::expired_type           res_wdata;
   dwt_pkg::div_req_type           div_req;
   dwt_pkg::div_rsp_type           div_rsp;
   logic                           div_kind;
   logic                           need_div;
   logic                           last_slot;
   logic                           advance;
   logic                           out_free;
   logic [dwt_pkg::DIV_W-1:0]      d_eff;
   logic [PW-1:0]                  prod;

   dwt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_eff    = rd_valid_ff ? rd_ff : '0;
   assign div_kind  = (rd_eff.kind == dwt_pkg::KIND_RECORD) ||
                      (rd_eff.kind == dwt_pkg::KIND_LONG_JOB);
   assign need_div  = div_kind && (big_ff || (dscale_ff != dwt_pkg::AGE_W'(1)));
   assign last_slot = (slot_ff == AW'(SLOTS - 1));
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign d_eff     = (age_divisor_ff == '0) ? dwt_pkg::DIV_W'(1) : age_divisor_ff;
   assign prod      = {{dwt_pkg::DIV_W{1'b0}}, dscale_ff} *
                      {{dwt_pkg::AGE_W{1'b0}}, d_eff};

   assign res_wdata.idx  = dwt_pkg::IDX_W'(slot_ff);
   assign res_wdata.id   = rd_eff.id;
   assign res_wdata.kind = rd_eff.kind;

   assign age_divisor_in = csr_wr_en ? csr_wr_data : age_divisor_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      slot_in      = slot_ff;
      valid_in     = valid_ff;
      free_cnt_in  = free_cnt_ff;
      res_cnt_in   = res_cnt_ff;
      out_k_in     = out_k_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      peer_in      = peer_ff;
      rec_in       = rec_ff;
      dscale_in    = dscale_ff;
      big_in       = big_ff;
      kill_in      = kill_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      id_in        = id_ff;
      dl_in        = dl_ff;
      kind_in      = kind_ff;
      av_in        = av_ff;
      eff_age_in   = eff_age_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      mem_we       = 1'b0;
      mem_wdata    = rd_eff;
      res_we       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rd_eff.age;
      div_req.divisor  = dscale_ff;
      advance      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in      = req_bus.operation;
               id_in      = req_bus.entry_id;
               dl_in      = req_bus.deadline_ticks;
               kind_in    = req_bus.entry_kind;
               av_in      = req_bus.age_value;
               key_in     = (req_bus.operation == dwt_pkg::OP_REGISTER) ?
                            '0 : req_bus.entry_id;
               slot_in    = '0;
               found_in   = 1'b0;
               idx_in     = dwt_pkg::IDX_W'(SLOTS);
               peer_in    = 1'b0;
               rec_in     = 1'b0;
               res_cnt_in = '0;
               out_k_in   = '0;
               dscale_in  = dwt_pkg::AGE_W'(1);
               big_in     = 1'b0;
               kill_in    = 1'b0;
               case (req_bus.operation)
                  dwt_pkg::OP_REGISTER, dwt_pkg::OP_REMOVE, dwt_pkg::OP_SET_AGE: begin
                     mode_in  = M_MATCH;
                     state_in = S_RD;
                  end
                  dwt_pkg::OP_TICK: begin
                     mode_in  = M_TICK;
                     state_in = S_RD;
                  end
                  dwt_pkg::OP_SWEEP: begin
                     mode_in  = M_SWEEP;
                     state_in = S_RD;
                  end
                  default: begin
                     state_in = S_ORES;
                  end
               endcase
            end
         end

         S_RD: begin
            state_in = S_EV;
         end

         S_EV: begin
            case (mode_ff)
               M_MATCH: begin
                  if (rd_eff.id == key_ff) begin
                     found_in = 1'b1;
                     idx_in   = dwt_pkg::IDX_W'(slot_ff);
                     state_in = S_ORES;
                     case (op_ff)
                        dwt_pkg::OP_REGISTER: begin
                           mem_we             = 1'b1;
                           mem_wdata.id       = id_ff;
                           mem_wdata.age      = '0;
                           mem_wdata.deadline = dl_ff;
                           mem_wdata.kind     = kind_ff;
                           valid_in[slot_ff]  = 1'b1;
                           if (id_ff != '0) begin
                              free_cnt_in = free_cnt_ff - dwt_pkg::IDX_W'(1);
                           end
                        end
                        dwt_pkg::OP_REMOVE: begin
                           valid_in[slot_ff] = 1'b0;
                           if (key_ff != '0) begin
                              free_cnt_in = free_cnt_ff + dwt_pkg::IDX_W'(1);
                           end
                        end
                        dwt_pkg::OP_SET_AGE: begin
                           mem_we            = 1'b1;
                           mem_wdata.age     = av_ff;
                           valid_in[slot_ff] = 1'b1;
                        end
                        default: begin
                           mem_we = 1'b0;
                        end
                     endcase
                  end else begin
                     advance = 1'b1;
                  end
               end
               M_TICK: begin
                  if ((rd_eff.id != '0) && (rd_eff.age != dwt_pkg::AGE_MAX)) begin
                     mem_we            = 1'b1;
                     mem_wdata.age     = rd_eff.age + dwt_pkg::AGE_W'(1);
                     valid_in[slot_ff] = 1'b1;
                  end
                  advance = 1'b1;
               end
               M_SWEEP, M_DIVP: begin
                  if (need_div && !big_ff) begin
                     div_req.start = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     eff_age_in = need_div ? '0 : rd_eff.age;
                     state_in   = S_CMP;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_DIV: begin
            if (div_rsp.done) begin
               eff_age_in = div_rsp.quotient;
               state_in   = S_CMP;
            end
         end

         S_CMP: begin
            if (mode_ff == M_SWEEP) begin
               if ((rd_eff.id > dwt_pkg::ID_W'(1)) && (eff_age_ff > rd_eff.deadline)) begin
                  case (rd_eff.kind)
                     dwt_pkg::KIND_HB_SEND, dwt_pkg::KIND_HB_RECV: begin
                        peer_in = 1'b1;
                     end
                     dwt_pkg::KIND_RECORD, dwt_pkg::KIND_VIEW,
                     dwt_pkg::KIND_LONG_JOB: begin
                        res_we            = 1'b1;
                        res_cnt_in        = res_cnt_ff + CW'(1);
                        valid_in[slot_ff] = 1'b0;
                        free_cnt_in       = free_cnt_ff + dwt_pkg::IDX_W'(1);
                        if (rd_eff.kind != dwt_pkg::KIND_VIEW) begin
                           kill_in = 1'b1;
                           if (big_ff || (prod[PW-1:dwt_pkg::AGE_W] != '0)) begin
                              big_in = 1'b1;
                           end else begin
                              dscale_in = prod[dwt_pkg::AGE_W-1:0];
                           end
                        end
                        if (rd_eff.kind == dwt_pkg::KIND_RECORD) begin
                           rec_in = 1'b1;
                        end
                     end
                     default: begin
                        peer_in = peer_ff;
                     end
                  endcase
               end
            end else if (div_kind) begin
               mem_we            = 1'b1;
               mem_wdata.age     = eff_age_ff;
               valid_in[slot_ff] = 1'b1;
            end
            advance = 1'b1;
         end

         S_ORES: begin
            if (out_k_ff < res_cnt_ff) begin
               state_in = S_OLD;
            end else begin
               state_in = S_OLAST;
            end
         end

         S_OLD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found          = 1'b1;
               rsp_in.slot_index     = res_rd_ff.idx;
               rsp_in.free_slots     = free_cnt_ff;
               rsp_in.expired_valid  = 1'b1;
               rsp_in.expired_id     = res_rd_ff.id;
               rsp_in.expired_kind   = res_rd_ff.kind;
               rsp_in.peer_error     = 1'b0;
               rsp_in.record_expired = 1'b0;
               rsp_in.last           = 1'b0;
               out_k_in              = out_k_ff + CW'(1);
               state_in              = S_ORES;
            end
         end

         S_OLAST: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found          = found_ff;
               rsp_in.slot_index     = idx_ff;
               rsp_in.free_slots     = free_cnt_ff;
               rsp_in.expired_valid  = 1'b0;
               rsp_in.expired_id     = '0;
               rsp_in.expired_kind   = '0;
               rsp_in.peer_error     = peer_ff;
               rsp_in.record_expired = rec_ff;
               rsp_in.last           = 1'b1;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (last_slot) begin
            if ((mode_ff == M_SWEEP) && kill_in) begin
               mode_in  = M_DIVP;
               slot_in  = '0;
               state_in = S_RD;
            end else begin
               state_in = S_ORES;
            end
         end else begin
            slot_in  = slot_ff + AW'(1);
            state_in = S_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= M_MATCH;
         slot_ff        <= '0;
         valid_ff       <= '0;
         free_cnt_ff    <= dwt_pkg::IDX_W'(SLOTS);
         res_cnt_ff     <= '0;
         out_k_ff       <= '0;
         found_ff       <= 1'b0;
         idx_ff         <= dwt_pkg::IDX_W'(SLOTS);
         peer_ff        <= 1'b0;
         rec_ff         <= 1'b0;
         dscale_ff      <= dwt_pkg::AGE_W'(1);
         big_ff         <= 1'b0;
         kill_ff        <= 1'b0;
         age_divisor_ff <= dwt_pkg::AGE_DIV_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         slot_ff        <= slot_in;
         valid_ff       <= valid_in;
         free_cnt_ff    <= free_cnt_in;
         res_cnt_ff     <= res_cnt_in;
         out_k_ff       <= out_k_in;
         found_ff       <= found_in;
         idx_ff         <= idx_in;
         peer_ff        <= peer_in;
         rec_ff         <= rec_in;
         dscale_ff      <= dscale_in;
         big_ff         <= big_in;
         kill_ff        <= kill_in;
         age_divisor_ff <= age_divisor_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      id_ff      <= id_in;
      dl_ff      <= dl_in;
      kind_ff    <= kind_in;
      av_ff      <= av_in;
      eff_age_ff <= eff_age_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_ff] <= mem_wdata;
      end
      if (state_ff == S_RD) begin
         rd_ff       <= slot_mem[slot_ff];
         rd_valid_ff <= valid_ff[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_cnt_ff[AW-1:0]] <= res_wdata;
      end
      if ((state_ff == S_ORES) && (out_k_ff < res_cnt_ff)) begin
         res_rd_ff <= res_mem[out_k_ff[AW-1:0]];
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found          = rsp_ff.found;
   assign rsp_bus.slot_index     = rsp_ff.slot_index;
   assign rsp_bus.free_slots     = rsp_ff.free_slots;
   assign rsp_bus.expired_valid  = rsp_ff.expired_valid;
   assign rsp_bus.expired_id     = rsp_ff.expired_id;
   assign rsp_bus.expired_kind   = rsp_ff.expired_kind;
   assign rsp_bus.peer_error     = rsp_ff.peer_error;
   assign rsp_bus.record_expired = rsp_ff.record_expired;
   assign rsp_bus.last           = rsp_ff.last;

endmodule

// ----- rtl/dwt_chk.sv -----
// ============================================================================
// Deadline watchdog table checker
// Port-level checks on item accounting and result ordering of the table.
// ============================================================================
`include "deadline_watchdog_table_defines.svh"

module dwt_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_last,
   input logic [dwt_pkg::IDX_W-1:0] rsp_free_slots
);

   logic [1:0]                pend_ff, pend_in;
   logic                      mid_ff, mid_in;
   logic [dwt_pkg::IDX_W-1:0] free_hold_ff, free_hold_in;
   logic                      req_xfer;
   logic                      rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pend_in      = pend_ff;
      mid_in       = mid_ff;
      free_hold_in = free_hold_ff;
      if (req_xfer && !(rsp_xfer && rsp_last)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer && rsp_last) begin
         pend_in = pend_ff - 2'd1;
      end
      if (rsp_xfer) begin
         mid_in       = !rsp_last;
         free_hold_in = rsp_free_slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         mid_ff       <= 1'b0;
         free_hold_ff <= '0;
      end else begin
         pend_ff      <= pend_in;
         mid_ff       <= mid_in;
         free_hold_ff <= free_hold_in;
      end
   end

   // A stalled result stays offered.
   `DWT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // At most one item waits on its final transfer while the next is in work.
   `DWT_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1, pend_ff != 2'd3)
   // No result is offered without an accepted item behind it.
   `DWT_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_valid, pend_ff != 2'd0)
   // All results of one item report the same free count.
   `DWT_ASSERT_IMP(a_free_steady, clock, reset, rsp_valid && mid_ff, rsp_free_slots == free_hold_ff)

endmodule

bind deadline_watchdog_table dwt_chk u_dwt_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_last       (rsp_bus.last),
   .rsp_free_slots (rsp_bus.free_slots)
);
